// ----- src/pli_pkg.sv -----
// shared constants and types of the piecewise linear interpolator
`timescale 1ns / 1ps
package pli_pkg;

   localparam int MAX_POINTS_DEF = 64;

   localparam int DATA_W     = 32;
   localparam int IDX_W      = 6;
   localparam int SEG_W      = 6;
   localparam int STAT_W     = 2;
   localparam int CFG_W      = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // restoring divider over a 65 bit dividend, one quotient bit a step
   localparam int DVD_W     = 65;
   localparam int DIV_STEPS = 65;
   localparam int DCNT_W    = 7;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_ORDER  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_ZERO_W = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_POINTS_ADDR = 3'd0;
   localparam logic [CFG_W-1:0]      POINTS_RESET    = 7'd2;

   typedef enum logic [1:0] {
      RES_ORDER,
      RES_ZERO_W,
      RES_EXACT,
      RES_LERP
   } res_kind_type;

   typedef struct packed {
      logic load_wr;
      logic q_load;
      logic scan_rd;
      logic scan_first;
      logic scan_second;
      logic x_rd;
      logic y_rd;
      logic extrap_setup;
      logic interior_setup;
      logic srch_cmp;
      logic ya_cap;
      logic yb_cap;
      logic prep;
      logic mul;
      logic div_load;
      logic div_step;
      logic sum;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic disorder;
      logic q_eq_x0;
      logic q_ge_xl;
      logic q_lt_x0;
      logic x0_eq_x1;
      logic mid_le;
      logic q_eq_xlo;
   } dp_stat_type;

endpackage

// ----- src/pli_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module pli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/pli_ctrl.sv -----
// sequencer of the interpolator: order scan, binary search, segment fetch and divide
`timescale 1ns / 1ps
module pli_ctrl import pli_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [CFG_W-1:0]              cfg_points,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  dp_stat_type                   stat,
   output dp_cmd_type                    cmd,
   output logic [$clog2(MAX_POINTS)-1:0] x_addr,
   output logic [$clog2(MAX_POINTS)-1:0] y_addr,
   output logic [$clog2(MAX_POINTS)-1:0] seg,
   output res_kind_type                  kind
);

   localparam int AW = $clog2(MAX_POINTS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_SRCH_CHK,
      ST_SRCH_CMP,
      ST_HIT_CHK,
      ST_RD_YA,
      ST_CAP_YA,
      ST_RD_YB,
      ST_CAP_YB,
      ST_PREP,
      ST_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [AW-1:0]     cnt_ff;
   logic [AW-1:0]     n_last_ff;
   logic [AW-1:0]     lo_ff;
   logic [AW-1:0]     hi_ff;
   logic [AW-1:0]     seg_ff;
   logic [AW-1:0]     ya_addr_ff;
   logic [AW-1:0]     yb_addr_ff;
   logic              lerp_ff;
   logic [DCNT_W-1:0] div_cnt_ff;
   logic              rsp_valid_ff;
   res_kind_type      kind_ff;

   logic              req_acc;
   logic [AW-1:0]     mid;
   logic              span_gt1;
   logic [AW-1:0]     n_last_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign mid       = AW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign span_gt1  = ({1'b0, hi_ff} - {1'b0, lo_ff}) > (AW+1)'(1);

   // points in use clamped into 2..MAX_POINTS, kept as the last index
   always_comb begin
      if (32'(cfg_points) < 2) begin
         n_last_in = AW'(1);
      end else if (32'(cfg_points) > MAX_POINTS) begin
         n_last_in = AW'(MAX_POINTS - 1);
      end else begin
         n_last_in = AW'(32'(cfg_points) - 1);
      end
   end

   always_comb begin
      cmd    = '0;
      x_addr = cnt_ff;
      y_addr = ya_addr_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_wr = req_acc && (req_opcode == OP_LOAD);
            cmd.q_load  = req_acc && (req_opcode == OP_QUERY);
         end
         ST_SCAN: begin
            cmd.x_rd        = 1'b1;
            cmd.scan_rd     = 1'b1;
            cmd.scan_first  = (cnt_ff == '0);
            cmd.scan_second = (cnt_ff == AW'(1));
            x_addr          = cnt_ff;
         end
         ST_DECIDE: begin
            if (!stat.disorder && !stat.q_eq_x0 && !stat.q_ge_xl) begin
               cmd.extrap_setup   = stat.q_lt_x0 && !stat.x0_eq_x1;
               cmd.interior_setup = !stat.q_lt_x0;
            end
         end
         ST_SRCH_CHK: begin
            cmd.x_rd = span_gt1;
            x_addr   = mid;
         end
         ST_SRCH_CMP: cmd.srch_cmp = 1'b1;
         ST_RD_YA: begin
            cmd.y_rd = 1'b1;
            y_addr   = ya_addr_ff;
         end
         ST_CAP_YA: cmd.ya_cap = 1'b1;
         ST_RD_YB: begin
            cmd.ya_cap = 1'b1;
            cmd.y_rd   = 1'b1;
            y_addr     = yb_addr_ff;
         end
         ST_CAP_YB:   cmd.yb_cap   = 1'b1;
         ST_PREP:     cmd.prep     = 1'b1;
         ST_MUL:      cmd.mul      = 1'b1;
         ST_DIV_LOAD: cmd.div_load = 1'b1;
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.sum      = (div_cnt_ff == DCNT_W'(DIV_STEPS));
         end
         ST_FINISH: cmd.out_load = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         n_last_ff    <= AW'(1);
         lo_ff        <= '0;
         hi_ff        <= '0;
         seg_ff       <= '0;
         ya_addr_ff   <= '0;
         yb_addr_ff   <= '0;
         lerp_ff      <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= RES_ORDER;
      end else begin
         if (rsp_valid_ff && rsp_ready && !cmd.out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc && (req_opcode == OP_QUERY)) begin
                  n_last_ff <= n_last_in;
                  cnt_ff    <= '0;
                  state_ff  <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (cnt_ff == n_last_ff) begin
                  state_ff <= ST_SCAN_END;
               end else begin
                  cnt_ff <= cnt_ff + AW'(1);
               end
            end
            // last scanned abscissa is compared here
            ST_SCAN_END: state_ff <= ST_DECIDE;
            ST_DECIDE: begin
               seg_ff  <= '0;
               lerp_ff <= 1'b0;
               if (stat.disorder) begin
                  kind_ff  <= RES_ORDER;
                  state_ff <= ST_FINISH;
               end else if (stat.q_eq_x0) begin
                  ya_addr_ff <= '0;
                  state_ff   <= ST_RD_YA;
               end else if (stat.q_ge_xl) begin
                  ya_addr_ff <= n_last_ff;
                  seg_ff     <= n_last_ff - AW'(1);
                  state_ff   <= ST_RD_YA;
               end else if (stat.q_lt_x0) begin
                  if (stat.x0_eq_x1) begin
                     kind_ff  <= RES_ZERO_W;
                     state_ff <= ST_FINISH;
                  end else begin
                     ya_addr_ff <= '0;
                     yb_addr_ff <= AW'(1);
                     lerp_ff    <= 1'b1;
                     state_ff   <= ST_RD_YA;
                  end
               end else begin
                  lo_ff    <= '0;
                  hi_ff    <= n_last_ff;
                  state_ff <= ST_SRCH_CHK;
               end
            end
            ST_SRCH_CHK: begin
               if (span_gt1) begin
                  state_ff <= ST_SRCH_CMP;
               end else begin
                  seg_ff   <= lo_ff;
                  state_ff <= ST_HIT_CHK;
               end
            end
            ST_SRCH_CMP: begin
               if (stat.mid_le) begin
                  lo_ff <= mid;
               end else begin
                  hi_ff <= mid;
               end
               state_ff <= ST_SRCH_CHK;
            end
            ST_HIT_CHK: begin
               ya_addr_ff <= lo_ff;
               yb_addr_ff <= hi_ff;
               lerp_ff    <= !stat.q_eq_xlo;
               state_ff   <= ST_RD_YA;
            end
            ST_RD_YA: state_ff <= lerp_ff ? ST_RD_YB : ST_CAP_YA;
            ST_CAP_YA: begin
               kind_ff  <= RES_EXACT;
               state_ff <= ST_FINISH;
            end
            ST_RD_YB:  state_ff <= ST_CAP_YB;
            ST_CAP_YB: state_ff <= ST_PREP;
            ST_PREP:   state_ff <= ST_MUL;
            ST_MUL:    state_ff <= ST_DIV_LOAD;
            ST_DIV_LOAD: begin
               div_cnt_ff <= DCNT_W'(1);
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               if (div_cnt_ff == DCNT_W'(DIV_STEPS)) begin
                  kind_ff  <= RES_LERP;
                  state_ff <= ST_FINISH;
               end else begin
                  div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
               end
            end
            ST_FINISH: begin
               if (cmd.out_load) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign seg       = seg_ff;
   assign kind      = kind_ff;

endmodule

// ----- src/pli_dp.sv -----
// datapath of the interpolator: breakpoint rams, compares, multiplier and divider
`timescale 1ns / 1ps
module pli_dp import pli_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [IDX_W-1:0]              req_point_index,
   input  logic signed [DATA_W-1:0]      req_point_x,
   input  logic signed [DATA_W-1:0]      req_point_y,
   input  logic signed [DATA_W-1:0]      req_query_x,
   input  dp_cmd_type                    cmd,
   input  logic [$clog2(MAX_POINTS)-1:0] x_addr,
   input  logic [$clog2(MAX_POINTS)-1:0] y_addr,
   input  logic [$clog2(MAX_POINTS)-1:0] seg,
   input  res_kind_type                  kind,
   output dp_stat_type                   stat,
   output logic signed [DATA_W-1:0]      rsp_y_value,
   output logic [SEG_W-1:0]              rsp_segment_index,
   output logic [STAT_W-1:0]             rsp_status,
   output logic                          rsp_saturated
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int SW = DATA_W + 4;
   localparam logic signed [SW-1:0] S_MAX = SW'(64'sd2147483647);
   localparam logic signed [SW-1:0] S_MIN = SW'(-64'sd2147483648);

   logic                     wr_en;
   logic [DATA_W-1:0]        x_rd_data;
   logic [DATA_W-1:0]        y_rd_data;
   logic signed [DATA_W-1:0] xd;

   logic signed [DATA_W-1:0] q_ff, x0_ff, x1_ff, xl_ff, prev_ff, x_lo_ff, x_hi_ff;
   logic signed [DATA_W-1:0] ya_ff, yb_ff, base_ff;
   logic                     disorder_ff, extrap_ff;
   logic                     sv_ff, sf_ff, ss_ff;
   logic [DATA_W-1:0]        mdy_ff, mdx_ff, w_ff;
   logic                     neg_ff;
   logic [2*DATA_W-1:0]      prod_ff;
   logic [DVD_W-1:0]         dvd_ff;
   logic [DATA_W-1:0]        rem_ff;
   logic signed [DATA_W-1:0] res_ff;
   logic                     res_sat_ff;
   logic signed [DATA_W-1:0] y_out_ff;
   logic [SEG_W-1:0]         seg_out_ff;
   logic [STAT_W-1:0]        status_out_ff;
   logic                     sat_out_ff;

   logic signed [DATA_W:0]   dy_w, dx_w, dw_w;
   logic signed [DATA_W-1:0] xsel;
   logic [DATA_W:0]          rem_sh;
   logic                     q_bit;
   logic [DVD_W-1:0]         quot_w;
   logic signed [SW-1:0]     base_w, qs_w, sum_w;

   assign wr_en = cmd.load_wr && (32'(req_point_index) < MAX_POINTS);

   pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_x_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_point_index)),
      .wr_data (req_point_x),
      .rd_en   (cmd.x_rd),
      .rd_addr (x_addr),
      .rd_data (x_rd_data)
   );

   pli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_y_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_point_index)),
      .wr_data (req_point_y),
      .rd_en   (cmd.y_rd),
      .rd_addr (y_addr),
      .rd_data (y_rd_data)
   );

   assign xd = x_rd_data;

   assign stat.disorder = disorder_ff;
   assign stat.q_eq_x0  = (q_ff == x0_ff);
   assign stat.q_ge_xl  = (q_ff >= xl_ff);
   assign stat.q_lt_x0  = (q_ff < x0_ff);
   assign stat.x0_eq_x1 = (x0_ff == x1_ff);
   assign stat.mid_le   = (xd <= q_ff);
   assign stat.q_eq_xlo = (q_ff == x_lo_ff);

   // segment differences, 33 bits so that no difference overflows
   assign xsel = extrap_ff ? x_hi_ff : x_lo_ff;
   assign dy_w = {yb_ff[DATA_W-1], yb_ff} - {ya_ff[DATA_W-1], ya_ff};
   assign dx_w = {q_ff[DATA_W-1], q_ff} - {xsel[DATA_W-1], xsel};
   assign dw_w = {x_hi_ff[DATA_W-1], x_hi_ff} - {x_lo_ff[DATA_W-1], x_lo_ff};

   assign rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, w_ff});

   // full quotient including the bit of the step in progress
   assign quot_w = {dvd_ff[DVD_W-2:0], q_bit};

   assign base_w = SW'(base_ff);
   assign qs_w   = SW'({1'b0, quot_w[DATA_W+1:0]});
   assign sum_w  = neg_ff ? (base_w - qs_w) : (base_w + qs_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
         sf_ff <= 1'b0;
         ss_ff <= 1'b0;
      end else begin
         sv_ff <= cmd.scan_rd;
         sf_ff <= cmd.scan_first;
         ss_ff <= cmd.scan_second;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.q_load) begin
         q_ff <= req_query_x;
      end
      // order scan, one abscissa a cycle from the ram
      if (sv_ff) begin
         if (sf_ff) begin
            x0_ff       <= xd;
            disorder_ff <= 1'b0;
         end else if (prev_ff > xd) begin
            disorder_ff <= 1'b1;
         end
         if (ss_ff) begin
            x1_ff <= xd;
         end
         prev_ff <= xd;
         xl_ff   <= xd;
      end
      if (cmd.extrap_setup) begin
         x_lo_ff   <= x0_ff;
         x_hi_ff   <= x1_ff;
         extrap_ff <= 1'b1;
      end
      if (cmd.interior_setup) begin
         x_lo_ff   <= x0_ff;
         x_hi_ff   <= xl_ff;
         extrap_ff <= 1'b0;
      end
      if (cmd.srch_cmp) begin
         if (stat.mid_le) begin
            x_lo_ff <= xd;
         end else begin
            x_hi_ff <= xd;
         end
      end
      if (cmd.ya_cap) begin
         ya_ff <= y_rd_data;
      end
      if (cmd.yb_cap) begin
         yb_ff <= y_rd_data;
      end
      if (cmd.prep) begin
         mdy_ff  <= dy_w[DATA_W] ? DATA_W'(-dy_w) : dy_w[DATA_W-1:0];
         mdx_ff  <= dx_w[DATA_W] ? DATA_W'(-dx_w) : dx_w[DATA_W-1:0];
         w_ff    <= dw_w[DATA_W-1:0];
         neg_ff  <= dy_w[DATA_W] ^ dx_w[DATA_W];
         base_ff <= extrap_ff ? yb_ff : ya_ff;
      end
      if (cmd.mul) begin
         prod_ff <= mdy_ff * mdx_ff;
      end
      // half the width added first gives round to nearest, ties away from zero
      if (cmd.div_load) begin
         dvd_ff <= DVD_W'(prod_ff) + DVD_W'(w_ff >> 1);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? DATA_W'(rem_sh - {1'b0, w_ff}) : rem_sh[DATA_W-1:0];
         dvd_ff <= {dvd_ff[DVD_W-2:0], q_bit};
      end
      if (cmd.sum) begin
         // sum is taken in the final divide step, on the quotient including that step's bit
         if (|quot_w[DVD_W-1:DATA_W+2]) begin
            res_sat_ff <= 1'b1;
            res_ff     <= neg_ff ? DATA_W'(S_MIN) : DATA_W'(S_MAX);
         end else if (sum_w > S_MAX) begin
            res_sat_ff <= 1'b1;
            res_ff     <= DATA_W'(S_MAX);
         end else if (sum_w < S_MIN) begin
            res_sat_ff <= 1'b1;
            res_ff     <= DATA_W'(S_MIN);
         end else begin
            res_sat_ff <= 1'b0;
            res_ff     <= DATA_W'(sum_w);
         end
      end
      if (cmd.out_load) begin
         seg_out_ff <= SEG_W'(seg);
         case (kind)
            RES_ORDER: begin
               y_out_ff      <= '0;
               status_out_ff <= STATUS_ORDER;
               sat_out_ff    <= 1'b0;
            end
            RES_ZERO_W: begin
               y_out_ff      <= '0;
               status_out_ff <= STATUS_ZERO_W;
               sat_out_ff    <= 1'b0;
            end
            RES_EXACT: begin
               y_out_ff      <= ya_ff;
               status_out_ff <= STATUS_OK;
               sat_out_ff    <= 1'b0;
            end
            default: begin
               y_out_ff      <= res_ff;
               status_out_ff <= STATUS_OK;
               sat_out_ff    <= res_sat_ff;
            end
         endcase
      end
   end

   assign rsp_y_value       = y_out_ff;
   assign rsp_segment_index = seg_out_ff;
   assign rsp_status        = status_out_ff;
   assign rsp_saturated     = sat_out_ff;

endmodule

// ----- src/piecewise_linear_interpolator_core.sv -----
// piecewise linear interpolator over a Q16.16 breakpoint table
// requests come in on req_* (valid/ready); opcode 0 loads point_x/point_y into
// slot point_index, opcode 1 evaluates query_x against the first points_in_use
// breakpoints. a load gives no response and leaves the block idle; a query gives
// one response on rsp_* with y_value, segment_index, status and saturated.
// points_in_use lives at csr byte address 0 and is written through the apb-style
// csr_* port; the user must write it only while the block is idle, the block does
// not enforce this; reset sets it to 2. a query runs the order scan (one ram
// read a cycle), then the binary search steps and the segment fetch, and for an
// interpolated result the multiply and the bit-serial divider; exact hits skip
// the multiply and the divide.
// one query is in flight at a time; req_ready is high only between queries.
// a finished response sits in the output register until taken; a new request
// is accepted meanwhile, but the next response waits for rsp_ready.
// reset clears the sequencer and the response valid; table contents are kept
// and are undefined until loaded.
`timescale 1ns / 1ps
module piecewise_linear_interpolator_core import pli_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [IDX_W-1:0]             req_point_index,
   input  logic signed [DATA_W-1:0]     req_point_x,
   input  logic signed [DATA_W-1:0]     req_point_y,
   input  logic signed [DATA_W-1:0]     req_query_x,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_W-1:0]     rsp_y_value,
   output logic [SEG_W-1:0]             rsp_segment_index,
   output logic [STAT_W-1:0]            rsp_status,
   output logic                         rsp_saturated,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [CSR_DATA_W-1:0]        csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   localparam int AW = $clog2(MAX_POINTS);

   logic [CFG_W-1:0] points_ff;
   dp_cmd_type       cmd;
   dp_stat_type      stat;
   logic [AW-1:0]    x_addr;
   logic [AW-1:0]    y_addr;
   logic [AW-1:0]    seg;
   res_kind_type     kind;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_POINTS_ADDR) ? CSR_DATA_W'(points_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= POINTS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == REG_POINTS_ADDR)) begin
         points_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   pli_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .cfg_points (points_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .stat       (stat),
      .cmd        (cmd),
      .x_addr     (x_addr),
      .y_addr     (y_addr),
      .seg        (seg),
      .kind       (kind)
   );

   pli_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_point_index   (req_point_index),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_query_x       (req_query_x),
      .cmd               (cmd),
      .x_addr            (x_addr),
      .y_addr            (y_addr),
      .seg               (seg),
      .kind              (kind),
      .stat              (stat),
      .rsp_y_value       (rsp_y_value),
      .rsp_segment_index (rsp_segment_index),
      .rsp_status        (rsp_status),
      .rsp_saturated     (rsp_saturated)
   );

   // an accepted query holds off further requests until it completes
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OP_QUERY)) |=> !req_ready)
      else $error("request taken while a query is in flight");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |->
         ((rsp_y_value == '0) && !rsp_saturated && (rsp_segment_index == '0)))
      else $error("error response carries a value");

   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         ((rsp_y_value == 32'sh7FFFFFFF) || (rsp_y_value == 32'sh80000000)))
      else $error("saturated response not on a rail");

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OP_LOAD) && !rsp_valid) |=> !rsp_valid)
      else $error("load produced a response");

endmodule

// ----- bench/pli_checker.sv -----
// request and response monitor with lookup prediction and comparison
`timescale 1ns / 1ps
module pli_checker import pli_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     req_opcode,
   input  logic [IDX_W-1:0]         req_point_index,
   input  logic signed [DATA_W-1:0] req_point_x,
   input  logic signed [DATA_W-1:0] req_point_y,
   input  logic signed [DATA_W-1:0] req_query_x,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [DATA_W-1:0]        rsp_y_value,
   input  logic [SEG_W-1:0]         rsp_segment_index,
   input  logic [STAT_W-1:0]        rsp_status,
   input  logic                     rsp_saturated,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   input  logic                     csr_pready,
   output int                       fail_count,
   output int                       lookups_due
);

   typedef struct packed {
      logic [DATA_W-1:0] y_value;
      logic [SEG_W-1:0]  segment;
      logic [STAT_W-1:0] status;
      logic              saturated;
   } lookup_result_type;

   longint         bp_x [MAX_POINTS_DEF];
   longint         bp_y [MAX_POINTS_DEF];
   logic [CFG_W-1:0] active_points;
   lookup_result_type expected_lookups [$];

   // ya + dy*dx/dw, magnitude rounded half away from zero, then clipped
   function automatic longint blend(longint ya, longint dy, longint dx, longint dw,
                                    output bit sat);
      logic [127:0] mdy, mdx, prod, quot;
      bit           neg;
      longint       s;
      mdy  = dy < 0 ? -dy : dy;
      mdx  = dx < 0 ? -dx : dx;
      neg  = (dy < 0) != (dx < 0);
      prod = mdy * mdx;
      quot = (prod + 128'(dw / 2)) / 128'(dw);
      sat  = 0;
      if (quot >= (128'd1 << 34)) begin
         sat = 1;
         return neg ? -64'sd2147483648 : 64'sd2147483647;
      end
      s = neg ? ya - longint'(quot) : ya + longint'(quot);
      if (s > 64'sd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      if (s < -64'sd2147483648) begin
         sat = 1;
         return -64'sd2147483648;
      end
      return s;
   endfunction

   function automatic lookup_result_type predict_lookup(longint q);
      lookup_result_type r;
      int     n, lo, hi, mid;
      longint y;
      bit     sat;
      n = active_points;
      if (n < 2) n = 2;
      if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
      r = '0;
      y = 0;
      sat = 0;
      r.status = STATUS_OK;
      for (int i = 0; i + 1 < n; i++)
         if (bp_x[i] > bp_x[i+1]) r.status = STATUS_ORDER;
      if (r.status == STATUS_OK) begin
         if (q == bp_x[0]) begin
            y = bp_y[0];
         end else if (q >= bp_x[n-1]) begin
            y = bp_y[n-1];
            r.segment = SEG_W'(n - 2);
         end else if (q < bp_x[0]) begin
            if (bp_x[1] == bp_x[0])
               r.status = STATUS_ZERO_W;
            else
               y = blend(bp_y[1], bp_y[1] - bp_y[0], q - bp_x[1], bp_x[1] - bp_x[0], sat);
         end else begin
            lo = 0;
            hi = n - 1;
            while (hi - lo > 1) begin
               mid = (lo + hi) / 2;
               if (bp_x[mid] <= q) lo = mid;
               else hi = mid;
            end
            r.segment = SEG_W'(lo);
            if (bp_x[lo] == q)
               y = bp_y[lo];
            else
               y = blend(bp_y[lo], bp_y[lo+1] - bp_y[lo], q - bp_x[lo],
                         bp_x[lo+1] - bp_x[lo], sat);
         end
      end
      r.y_value   = DATA_W'(y);
      r.saturated = sat;
      return r;
   endfunction

   assign lookups_due = expected_lookups.size();

   always @(posedge clock) begin
      lookup_result_type exp_r;
      if (reset) begin
         fail_count = 0;
         active_points = POINTS_RESET;
         expected_lookups.delete();
         for (int i = 0; i < MAX_POINTS_DEF; i++) begin
            bp_x[i] = 0;
            bp_y[i] = 0;
         end
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == REG_POINTS_ADDR)
            active_points = csr_pwdata[CFG_W-1:0];
         if (rsp_valid && rsp_ready) begin
            if (expected_lookups.size() == 0) begin
               $display("%0t: response with no request outstanding, y %h", $time,
                        rsp_y_value);
               fail_count++;
            end else begin
               exp_r = expected_lookups.pop_front();
               if (rsp_y_value !== exp_r.y_value) begin
                  $display("%0t: y_value expected %h actual %h", $time,
                           exp_r.y_value, rsp_y_value);
                  fail_count++;
               end
               if (rsp_segment_index !== exp_r.segment) begin
                  $display("%0t: segment_index expected %0d actual %0d", $time,
                           exp_r.segment, rsp_segment_index);
                  fail_count++;
               end
               if (rsp_status !== exp_r.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           exp_r.status, rsp_status);
                  fail_count++;
               end
               if (rsp_saturated !== exp_r.saturated) begin
                  $display("%0t: saturated expected %b actual %b", $time,
                           exp_r.saturated, rsp_saturated);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_opcode == OP_LOAD) begin
               bp_x[req_point_index] = longint'(req_point_x);
               bp_y[req_point_index] = longint'(req_point_y);
            end else begin
               expected_lookups.push_back(predict_lookup(longint'(req_query_x)));
            end
         end
      end
   end

endmodule

// ----- bench/tb_piecewise_linear_interpolator_core.sv -----
// stimulus and verdict for the piecewise linear interpolator core
`timescale 1ns / 1ps
module tb_piecewise_linear_interpolator_core;
   import pli_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 200;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_ready;
   logic                     req_opcode = OP_LOAD;
   logic [IDX_W-1:0]         req_point_index = '0;
   logic signed [DATA_W-1:0] req_point_x = '0;
   logic signed [DATA_W-1:0] req_point_y = '0;
   logic signed [DATA_W-1:0] req_query_x = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 0;
   logic signed [DATA_W-1:0] rsp_y_value;
   logic [SEG_W-1:0]         rsp_segment_index;
   logic [STAT_W-1:0]        rsp_status;
   logic                     rsp_saturated;
   logic                     csr_psel = 0;
   logic                     csr_penable = 0;
   logic                     csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0]    csr_paddr = '0;
   logic [CSR_DATA_W-1:0]    csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]    csr_prdata;
   logic                     csr_pready;

   int          fail_count, lookups_due;
   int          cycle_count = 0;
   int          sender_gap_pct = 0;
   int          stall_pct = 0;
   bit          hold_request = 0;
   int          hold_left = 0;
   int          points = 2;
   logic [31:0] shadow_x [MAX_POINTS_DEF];

   always #6 clock = ~clock;

   piecewise_linear_interpolator_core DUT (.*);

   pli_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_opcode, .req_point_index,
      .req_point_x, .req_point_y, .req_query_x, .rsp_valid, .rsp_ready,
      .rsp_y_value, .rsp_segment_index, .rsp_status, .rsp_saturated,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .fail_count, .lookups_due
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // response side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = 3000;
         hold_request = 0;
      end
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // valid stays high across back to back requests and drops only in a gap or a drain
   task automatic send_request(logic op, logic [IDX_W-1:0] idx, logic [31:0] px,
                               logic [31:0] py, logic [31:0] qx);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid       <= 1;
      req_opcode      <= op;
      req_point_index <= idx;
      req_point_x     <= px;
      req_point_y     <= py;
      req_query_x     <= qx;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic load_point(int idx, logic [31:0] px, logic [31:0] py);
      shadow_x[idx] = px;
      send_request(OP_LOAD, IDX_W'(idx), px, py, $urandom);
   endtask

   task automatic lookup(logic [31:0] qx);
      send_request(OP_QUERY, IDX_W'($urandom), $urandom, $urandom, qx);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (lookups_due != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_points(logic [CSR_DATA_W-1:0] value);
      drain();
      csr_psel    <= 1;
      csr_pwrite  <= 1;
      csr_paddr   <= REG_POINTS_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      points = value[CFG_W-1:0];
      if (points < 2) points = 2;
      if (points > MAX_POINTS_DEF) points = MAX_POINTS_DEF;
   endtask

   function automatic logic [31:0] rand_y();
      if ($urandom_range(1)) return $urandom;
      return 32'($urandom_range(32'h40000)) - 32'h20000;
   endfunction

   // mostly ascending tables, some with repeated abscissas, a few out of order
   task automatic build_table();
      logic [31:0] xs [MAX_POINTS_DEF];
      logic [31:0] tmp;
      int          span;
      span = $urandom_range(3) == 0 ? 31 : $urandom_range(24, 8);
      for (int i = 0; i < points; i++)
         xs[i] = (i > 0 && $urandom_range(9) == 0) ? xs[i-1]
               : 32'($signed($urandom) >>> (31 - span));
      if ($urandom_range(9) != 0)
         for (int i = 1; i < points; i++)
            for (int j = i; j > 0 && $signed(xs[j-1]) > $signed(xs[j]); j--) begin
               tmp = xs[j]; xs[j] = xs[j-1]; xs[j-1] = tmp;
            end
      for (int i = 0; i < points; i++) load_point(i, xs[i], rand_y());
   endtask

   task automatic random_lookup();
      int k;
      k = $urandom_range(points - 1);
      case ($urandom_range(9))
         0, 1, 2: lookup(shadow_x[k]);
         3: lookup(shadow_x[0] - $urandom_range(1, 1 << $urandom_range(30)));
         4: lookup(shadow_x[points-1] + $urandom_range(1 << $urandom_range(30)));
         5: lookup($urandom);
         6: load_point($urandom_range(63), $urandom, $urandom);
         default: begin
            k = $urandom_range(points - 2);
            lookup(shadow_x[k] +
                   32'((64'(shadow_x[k+1] - shadow_x[k]) * $urandom_range(1000)) / 1000));
         end
      endcase
   endtask

   task automatic random_phase(int gap, int stall, int cfg, int rounds, bit pressure);
      sender_gap_pct = 0;
      stall_pct = 0;
      write_points(cfg);
      sender_gap_pct = gap;
      stall_pct = stall;
      if (pressure) hold_request = 1;
      repeat (rounds) begin
         build_table();
         repeat ($urandom_range(12, 6)) random_lookup();
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: default two points
      load_point(0, 32'h0000_0000, 32'h0000_0000);
      load_point(1, 32'h0001_0000, 32'h7fff_ffff);
      lookup(32'h0000_0000);
      lookup(32'h0000_8000);
      lookup(32'h0001_0000);
      lookup(32'h7fff_ffff);
      lookup(32'h8000_0000);
      lookup(32'hffff_8000);
      load_point(1, 32'h0000_0000, 32'h8000_0000);
      lookup(32'h8000_0000);
      lookup(32'h0000_0000);
      lookup(32'h7fff_ffff);
      load_point(0, 32'h7fff_ffff, 32'h1234_5678);
      lookup(32'h0000_0000);
      load_point(0, 32'h8000_0000, 32'h8000_0000);
      load_point(1, 32'h7fff_ffff, 32'h7fff_ffff);
      lookup(32'h0000_0000);
      lookup(32'h0000_0001);
      lookup(32'h7fff_fffe);
      for (int i = 2; i < MAX_POINTS_DEF; i++)
         load_point(i, 32'h7fff_ffff, 32'($urandom));
      load_point(63, 32'h7fff_ffff, 32'hffff_ffff);

      random_phase(0,  0,  2,   3, 0);
      random_phase(0,  0,  64,  1, 1);
      random_phase(49, 0,  0,   3, 0);
      random_phase(0,  49, 127, 1, 0);
      random_phase(23, 23, 5,   3, 0);
      random_phase(49, 0,  1,   2, 0);
      random_phase(0,  49, 3,   3, 0);
      random_phase(23, 23, $urandom_range(4, 12), 2, 0);
      random_phase(0,  0,  32,  1, 0);

      req_valid <= 0;
      while (lookups_due != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
